[rtl/core/bis_pkg.sv]
`timescale 1ns / 1ps

package bis_pkg;

  // Width of one batch element.
  localparam int DATA_W = 32;

  // Default store capacity.
  localparam int MAX_ITEMS_DEF = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLACE0,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;       // input transfer this cycle
    logic scan;       // one step of the downward shift search
    logic place0;     // new element goes to the bottom of the store
    logic emit_rd;    // read the next stored element for output
    logic emit_ld;    // load the output register
    logic emit_next;  // output transfer done, more to come
    logic emit_end;   // output transfer of the final element done
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;       // store holds the maximum number of elements
    logic empty;      // store holds nothing
    logic greater;    // element read from the store is above the new one
    logic idx_zero;   // search has reached the bottom entry
    logic last_pend;  // the element being inserted closes the batch
    logic out_taken;  // output transfer this cycle
    logic out_last;   // the element on the output is the final one
  } stat_t;

endpackage

[rtl/core/bis_item_if.sv]
`timescale 1ns / 1ps

interface bis_item_if;
  logic                                valid;
  logic                                ready;
  logic signed [bis_pkg::DATA_W-1:0]   value;
  logic                                last_in;

  modport source (output valid, output value, output last_in, input ready);
  modport sink (input valid, input value, input last_in, output ready);
endinterface

[rtl/core/bis_result_if.sv]
`timescale 1ns / 1ps

interface bis_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [bis_pkg::DATA_W-1:0]   sorted_value;
  logic                                last_out;
  logic                                dropped;

  modport source (output valid, output sorted_value, output last_out, output dropped,
                  input ready);
  modport sink (input valid, input sorted_value, input last_out, input dropped,
                output ready);
endinterface

[rtl/core/bis_ctrl.sv]
`timescale 1ns / 1ps

module bis_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_last,
  output logic           in_ready,
  input  bis_pkg::stat_t st,
  output bis_pkg::cmd_t  cmd
);

  bis_pkg::state_t state;
  bis_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bis_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      bis_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (st.full || st.empty) begin
            state_next = in_last ? bis_pkg::ST_EMIT_RD : bis_pkg::ST_IDLE;
          end else begin
            state_next = bis_pkg::ST_SCAN;
          end
        end
      end
      bis_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (st.greater) begin
          if (st.idx_zero) begin
            state_next = bis_pkg::ST_PLACE0;
          end
        end else begin
          state_next = st.last_pend ? bis_pkg::ST_EMIT_RD : bis_pkg::ST_IDLE;
        end
      end
      bis_pkg::ST_PLACE0: begin
        cmd.place0 = 1'b1;
        state_next = st.last_pend ? bis_pkg::ST_EMIT_RD : bis_pkg::ST_IDLE;
      end
      bis_pkg::ST_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_next  = bis_pkg::ST_EMIT_LD;
      end
      bis_pkg::ST_EMIT_LD: begin
        cmd.emit_ld = 1'b1;
        state_next  = bis_pkg::ST_EMIT_WAIT;
      end
      bis_pkg::ST_EMIT_WAIT: begin
        if (st.out_taken) begin
          if (st.out_last) begin
            cmd.emit_end = 1'b1;
            state_next   = bis_pkg::ST_IDLE;
          end else begin
            cmd.emit_next = 1'b1;
            state_next    = bis_pkg::ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = bis_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/bis_datapath.sv]
`timescale 1ns / 1ps

module bis_datapath #(
  parameter int MAX_ITEMS = bis_pkg::MAX_ITEMS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  bis_pkg::cmd_t                     cmd,
  input  logic signed [bis_pkg::DATA_W-1:0] value,
  input  logic                              last_in,
  output bis_pkg::stat_t                    st,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bis_pkg::DATA_W-1:0] sorted_value,
  output logic                              last_out,
  output logic                              dropped
);

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int DW = bis_pkg::DATA_W;

  logic [DW-1:0] mem [MAX_ITEMS];
  logic [DW-1:0] rdata;
  logic [DW-1:0] vin;

  logic [CW-1:0] count;
  logic          overflow;
  logic          last_pend;
  logic [AW-1:0] idx;
  logic [AW-1:0] eidx;

  logic [CW-1:0] count_m1;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;

  assign count_m1 = count - CW'(1);

  assign st.full      = (count == CW'(MAX_ITEMS));
  assign st.empty     = (count == '0);
  assign st.greater   = ($signed(rdata) > $signed(vin));
  assign st.idx_zero  = (idx == '0);
  assign st.last_pend = last_pend;
  assign st.out_taken = out_valid && out_ready;
  assign st.out_last  = last_out;

  // Single read port: search start, search step, or output sweep.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = eidx;
    if (cmd.take) begin
      rd_en   = 1'b1;
      rd_addr = count_m1[AW-1:0];
    end else if (cmd.scan) begin
      rd_en   = 1'b1;
      rd_addr = idx - AW'(1);
    end else if (cmd.emit_rd) begin
      rd_en   = 1'b1;
      rd_addr = eidx;
    end
  end

  // Single write port: direct store into an empty store, shift up, or placement.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx + AW'(1);
    wr_data = vin;
    if (cmd.take) begin
      wr_en   = !st.full && st.empty;
      wr_addr = '0;
      wr_data = value;
    end else if (cmd.scan) begin
      wr_en   = 1'b1;
      wr_addr = idx + AW'(1);
      wr_data = st.greater ? rdata : vin;
    end else if (cmd.place0) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = vin;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      vin       <= value;
      last_pend <= last_in;
      idx       <= count_m1[AW-1:0];
    end else if (cmd.scan && st.greater) begin
      idx <= idx - AW'(1);
    end
    if (cmd.emit_ld) begin
      sorted_value <= rdata;
      last_out     <= ((CW'(eidx) + CW'(1)) == count);
      dropped      <= overflow;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      overflow  <= 1'b0;
      eidx      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.take && st.full) begin
        overflow <= 1'b1;
      end
      if ((cmd.take && st.empty) || (cmd.scan && !st.greater) || cmd.place0) begin
        count <= count + CW'(1);
      end
      if (cmd.emit_ld) begin
        out_valid <= 1'b1;
      end else if (st.out_taken) begin
        out_valid <= 1'b0;
      end
      if (cmd.emit_next) begin
        eidx <= eidx + AW'(1);
      end
      if (cmd.emit_end) begin
        count    <= '0;
        overflow <= 1'b0;
        eidx     <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ITEMS))
    else $error("store count above capacity");

  a_out_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (count != '0))
    else $error("result presented from an empty store");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> (CW'(idx) < count_m1 + CW'(1)) && !st.full)
    else $error("search index outside the filled part of the store");

  a_batch_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_end |=> (count == '0) && !overflow && (eidx == '0))
    else $error("batch state not cleared after final result");
`endif

endmodule

[rtl/core/batch_integer_sorter.sv]
`timescale 1ns / 1ps

// Channel   Dir   Handshake      Payload
// item      in    valid/ready    value[31:0] signed, last_in
// result    out   valid/ready    sorted_value[31:0] signed, last_out, dropped
//
// Loading: an element taken into an empty store is written at its transfer, and one
// taken into a full store is discarded; otherwise a downward shift search over the
// store (one read, one write a cycle) moves each stored element above it up a place.
// Output: each result is read, loaded and then transferred; a stalled sink holds it.
// Reset (rst, synchronous) clears the controller, count and flags; the store needs
// no clearing pass since only filled entries are ever read.
// item.ready is high only while the block waits for input; result stalls hold the sweep.

module batch_integer_sorter #(
  parameter int MAX_ITEMS = bis_pkg::MAX_ITEMS_DEF
) (
  input logic          clk,
  input logic          rst,
  bis_item_if.sink     item,
  bis_result_if.source result
);

  bis_pkg::cmd_t  cmd;
  bis_pkg::stat_t st;

  // The controller sequences the insertion search and the output sweep; all
  // storage, comparison and counting live in the datapath.
  bis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_last  (item.last_in),
    .in_ready (item.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath keeps the batch in ascending order. A new element is inserted
  // after any equal ones by shifting larger entries up one place, top first.
  bis_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .value        (item.value),
    .last_in      (item.last_in),
    .st           (st),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .sorted_value (result.sorted_value),
    .last_out     (result.last_out),
    .dropped      (result.dropped)
  );

endmodule

[tb/batch_integer_sorter_tb.sv]
`timescale 1ns / 1ps

module batch_integer_sorter_tb;

  // Store capacity of the block under test.
  localparam int CAP = bis_pkg::MAX_ITEMS_DEF;

  // Number of random elements to send after the directed batches.
  localparam int RANDOM_ELEMENTS = 250;

  // Receiver hold-off that backs the block up and stalls its input.
  localparam int LONG_HOLD = 300;

  // Cycles allowed after the last expected result for stray results to show up.
  localparam int DRAIN_CYCLES = 40;

  localparam logic signed [bis_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [bis_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  // One result as the block should present it.
  typedef struct {
    logic signed [bis_pkg::DATA_W-1:0] sorted_value;
    logic                              last_out;
    logic                              dropped;
  } sorted_out_t;

  // Scoreboard: keeps its own ascending copy of the batch received so far and,
  // when a batch closes, turns it into the list of results that must come out.
  class sorted_batch_checker;
    int                                capacity = CAP;
    logic signed [bis_pkg::DATA_W-1:0] batch_sofar[$];
    logic                              overflow = 1'b0;
    sorted_out_t                       due_results[$];
    int                                errors = 0;

    task report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    function int outstanding();
      return due_results.size();
    endfunction

    // An element was taken by the block. Elements go in after any equal ones;
    // once the store is full they are discarded and the batch is marked.
    function void note_element(input logic signed [bis_pkg::DATA_W-1:0] v,
                               input logic l);
      int          pos;
      sorted_out_t r;
      if (batch_sofar.size() < capacity) begin
        pos = 0;
        while (pos < batch_sofar.size() && batch_sofar[pos] <= v) pos++;
        batch_sofar.insert(pos, v);
      end else begin
        overflow = 1'b1;
      end
      if (l) begin
        foreach (batch_sofar[k]) begin
          r.sorted_value = batch_sofar[k];
          r.last_out     = (k == batch_sofar.size() - 1);
          r.dropped      = overflow;
          due_results.insert(due_results.size(), r);
        end
        batch_sofar.delete();
        overflow = 1'b0;
      end
    endfunction

    task check_output(input logic signed [bis_pkg::DATA_W-1:0] got_value,
                      input logic got_last, input logic got_drop);
      sorted_out_t want;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %0d last %b dropped %b",
                                  got_value, got_last, got_drop));
        return;
      end
      want = due_results.pop_front();
      if (got_value !== want.sorted_value)
        report_mismatch($sformatf("sorted_value %0d, wanted %0d",
                                  got_value, want.sorted_value));
      if (got_last !== want.last_out)
        report_mismatch($sformatf("last_out %b, wanted %b (value %0d)",
                                  got_last, want.last_out, want.sorted_value));
      if (got_drop !== want.dropped)
        report_mismatch($sformatf("dropped %b, wanted %b (value %0d)",
                                  got_drop, want.dropped, want.sorted_value));
    endtask

    task report_leftovers();
      if (due_results.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", due_results.size()));
      if (batch_sofar.size() != 0)
        report_mismatch($sformatf("%0d elements sent in a batch that was never closed",
                                  batch_sofar.size()));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  bis_item_if   item_bus();
  bis_result_if result_bus();

  batch_integer_sorter #(
    .MAX_ITEMS(CAP)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .item(item_bus),
    .result(result_bus)
  );

  always #5 clk = ~clk;

  sorted_batch_checker checker_h = new();

  // When set, the sender offers elements back to back for the current batch.
  bit tx_calm = 1'b0;

  // Elements of the directed batch about to be sent.
  logic signed [bis_pkg::DATA_W-1:0] directed_batch[$];

  // Offers one element and waits for its transfer. All drives happen at a rising
  // edge, and ready is looked at right after the edge, where it still holds the
  // value the block presented at that edge. The valid line is only lowered when a
  // gap is drawn, so back-to-back elements never see two assignments in one step.
  task automatic send_element(input logic signed [bis_pkg::DATA_W-1:0] v,
                              input logic l);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.valid   <= 1'b1;
    item_bus.value   <= v;
    item_bus.last_in <= l;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    checker_h.note_element(v, l);
  endtask

  task automatic send_directed_batch();
    for (int i = 0; i < directed_batch.size(); i++)
      send_element(directed_batch[i], i == directed_batch.size() - 1);
  endtask

  // Element values: mostly full-range random, with a share of small values so that
  // equal elements are common, and a sprinkling of the extremes.
  function automatic logic signed [bis_pkg::DATA_W-1:0] pick_value();
    logic signed [bis_pkg::DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: v = VAL_MIN;
          1: v = VAL_MAX;
          2: v = '0;
          default: v = -1;
        endcase
      end
      1, 2, 3: v = $signed($urandom_range(0, 8)) - 4;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Waits at a rising edge until every expected result has been taken.
  task automatic wait_for_results();
    while (checker_h.outstanding() != 0) @(posedge clk);
  endtask

  // Result side. Each result gets a random hold-off, except in calm stretches where
  // ready stays high. Once, well into the run, the receiver holds off for a long
  // time so that the output stalls, the block stops taking elements and the sender
  // is left waiting with valid high.
  initial begin
    int  seen;
    int  hold;
    bit  rx_calm;
    seen    = 0;
    rx_calm = 1'b0;
    result_bus.ready <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (seen % 25 == 0) rx_calm = ($urandom_range(0, 2) == 0);
      if (seen == 40)
        hold = LONG_HOLD;
      else
        hold = rx_calm ? 0 : $urandom_range(0, 9);
      if (hold > 0) begin
        result_bus.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
      @(posedge clk);
      while (!result_bus.valid) @(posedge clk);
      checker_h.check_output(result_bus.sorted_value, result_bus.last_out,
                             result_bus.dropped);
      seen++;
    end
  end

  // Stimulus: directed batches first, then random batches, then the drain.
  initial begin
    int                                sent;
    int                                batch_no;
    int                                size;
    bit                                descending;
    logic signed [bis_pkg::DATA_W-1:0] v;

    rst              <= 1'b1;
    item_bus.valid   <= 1'b0;
    item_bus.value   <= '0;
    item_bus.last_in <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A batch of one element, the most negative value.
    directed_batch = '{VAL_MIN};
    send_directed_batch();

    // Both extremes, zero and its neighbors, with equal elements at each extreme
    // and a closing element equal to one already held.
    directed_batch = '{VAL_MAX, VAL_MIN, 0, -1, 1, VAL_MAX, VAL_MIN, 0};
    send_directed_batch();

    // Strictly descending: every new element has to travel to the bottom of the
    // store, which is the longest search for the batch size.
    directed_batch = '{100, 50, 10, 0, -10, -50, -100};
    send_directed_batch();

    // Ascending with a run of equal elements: each goes in above its equals.
    tx_calm = 1'b1;
    directed_batch = '{5, 5, 5, 6};
    send_directed_batch();

    // The sender goes quiet until every result of the directed part is out.
    item_bus.valid <= 1'b0;
    wait_for_results();
    @(posedge clk);

    // Random batches. Most are short; a few fill the store. One fills it exactly,
    // one overruns it by a single element (the closing element is then the one
    // discarded), and one overruns it by several.
    sent     = 0;
    batch_no = 0;
    while (sent < RANDOM_ELEMENTS) begin
      case (batch_no)
        3: size = CAP;
        6: size = CAP + 5;
        9: size = CAP + 1;
        default: size = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30)
                                                    : $urandom_range(1, 8);
      endcase
      tx_calm    = ($urandom_range(0, 3) == 0);
      descending = (batch_no == 3) || ($urandom_range(0, 4) == 0);
      v          = pick_value();
      for (int i = 0; i < size; i++) begin
        if (descending)
          v = (i == 0) ? v : v - $signed($urandom_range(0, 1000));
        else
          v = pick_value();
        send_element(v, i == size - 1);
      end
      sent += size;
      batch_no++;
    end

    item_bus.valid <= 1'b0;
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    checker_h.report_leftovers();
    if (checker_h.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: ends the run with an error report if the stimulus has not finished.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
